[rtl/core/lss_pkg.sv]
// Shared sizes, codes and types for the lottery slot selector.
// Used by lss_weight_store, lss_scan and lottery_slot_selector_top; no dependencies.
package lss_pkg;

	localparam int SLOTS       = 16;
	localparam int WEIGHT_BITS = 8;
	localparam int RAND_BITS   = 16;

	localparam int SLOT_BITS  = $clog2(SLOTS);
	localparam int TOTAL_BITS = $clog2(SLOTS * ((1 << WEIGHT_BITS) - 1) + 1);
	localparam int MEM_DEPTH  = 1 << SLOT_BITS;

	// Request codes on the cmd port.
	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef logic [SLOT_BITS-1:0]   slot_addr_t;
	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [TOTAL_BITS-1:0]  total_t;

	// Status of the cumulative-weight walk, reported to the controller.
	typedef struct packed {
		logic       hit;
		logic       last;
		slot_addr_t idx;
	} scan_status_t;

endpackage

[rtl/core/lss_weight_store.sv]
// Per-slot weight memory with registered synchronous read.
// Entries never written since reset read as zero. Depends on lss_pkg.
module lss_weight_store (
	input  logic                clk,
	input  logic                arst_n,
	input  lss_pkg::slot_addr_t rd_addr,
	input  logic                wr_en,
	input  lss_pkg::slot_addr_t wr_addr,
	input  lss_pkg::weight_t    wr_data,
	output lss_pkg::weight_t    rd_data
);

	lss_pkg::weight_t                   mem [0:lss_pkg::MEM_DEPTH-1];
	logic [lss_pkg::MEM_DEPTH-1:0]      valid_q;
	lss_pkg::weight_t                   rd_data_q;
	logic                               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

[rtl/core/lss_scan.sv]
// Walks the weight stream one slot per cycle while en is high, accumulating the running sum
// and flagging the first slot whose cumulative weight exceeds the ticket. Depends on lss_pkg.
module lss_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  logic                  en,
	input  lss_pkg::weight_t      weight,
	input  lss_pkg::total_t       ticket,
	output lss_pkg::scan_status_t status
);

	lss_pkg::total_t     cum_q;
	lss_pkg::slot_addr_t idx_q;
	lss_pkg::total_t     cum_next;

	assign cum_next = cum_q + lss_pkg::TOTAL_BITS'(weight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q <= '0;
			idx_q <= '0;
		end else if (clr) begin
			cum_q <= '0;
			idx_q <= '0;
		end else if (en) begin
			cum_q <= cum_next;
			idx_q <= idx_q + 1'b1;
		end
	end

	assign status.hit  = en && (cum_next > ticket);
	assign status.last = (idx_q == lss_pkg::SLOT_BITS'(lss_pkg::SLOTS - 1));
	assign status.idx  = idx_q;

endmodule

[rtl/core/lottery_slot_selector_top.sv]
// Lottery slot selector: weighted random choice among the slots of a weight table.
// A set reads the old weight in ST_SET_RD and writes the new one in ST_SET_WR; a draw
// forms the ticket in ST_MUL and walks the slots in ST_SCAN (an empty table skips the
// walk). busy falls as the strobe rises, so a new request is taken only once the last
// is done; a draw walks one slot per cycle through the weight memory read port.
// Reset clears the weight table (per-entry valid bits) and the total at once.
module lottery_slot_selector_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [3:0]  slot,
	input  logic [7:0]  weight,
	input  logic [15:0] random_value,
	output logic        done,
	output logic [3:0]  winner,
	output logic        found,
	output logic [11:0] total_tickets
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SET_RD = 3'd1;
	localparam logic [2:0] ST_SET_WR = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;

	localparam int PROD_BITS = lss_pkg::RAND_BITS + lss_pkg::TOTAL_BITS;
	localparam int SLOT_EXT  = lss_pkg::SLOT_BITS + 4;

	logic [2:0]                    state_q;
	lss_pkg::slot_addr_t           slot_addr_q;
	logic                          slot_ok_q;
	lss_pkg::weight_t              weight_q;
	logic [lss_pkg::RAND_BITS-1:0] rnd_q;
	lss_pkg::total_t               total_q;
	lss_pkg::total_t               ticket_q;
	logic                          done_q;
	lss_pkg::slot_addr_t           winner_q;
	logic                          found_q;

	lss_pkg::slot_addr_t   rd_addr;
	lss_pkg::weight_t      rd_data;
	logic                  wr_en;
	logic                  scan_clr;
	logic                  scan_en;
	lss_pkg::scan_status_t scan_st;
	logic [SLOT_EXT-1:0]   slot_ext;
	logic [PROD_BITS-1:0]  product;
	logic                  accept;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign slot_ext = SLOT_EXT'(slot);
	assign product  = PROD_BITS'(rnd_q) * PROD_BITS'(total_q);
	assign wr_en    = (state_q == ST_SET_WR) && slot_ok_q;
	assign scan_clr = (state_q == ST_MUL);
	assign scan_en  = (state_q == ST_SCAN);

	// The read port serves the old weight of a set, then walks the slots for a draw.
	always_comb begin
		case (state_q)
			ST_SET_RD: rd_addr = slot_addr_q;
			ST_SCAN:   rd_addr = scan_st.idx + 1'b1;
			default:   rd_addr = '0;
		endcase
	end

	lss_weight_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (slot_addr_q),
		.wr_data (weight_q),
		.rd_data (rd_data)
	);

	lss_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (scan_clr),
		.en     (scan_en),
		.weight (rd_data),
		.ticket (ticket_q),
		.status (scan_st)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_addr_q <= slot_ext[lss_pkg::SLOT_BITS-1:0];
			slot_ok_q   <= slot_ext < SLOT_EXT'(lss_pkg::SLOTS);
			weight_q    <= lss_pkg::WEIGHT_BITS'(weight);
			rnd_q       <= lss_pkg::RAND_BITS'(random_value);
		end
		if (state_q == ST_MUL) begin
			ticket_q <= product[lss_pkg::RAND_BITS +: lss_pkg::TOTAL_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			total_q  <= '0;
			done_q   <= 1'b0;
			winner_q <= '0;
			found_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (cmd == lss_pkg::CMD_DRAW) ? ST_MUL : ST_SET_RD;
					end
				end
				ST_SET_RD: begin
					state_q <= ST_SET_WR;
				end
				ST_SET_WR: begin
					// Swapping old for new weight keeps the total equal to the table sum.
					if (slot_ok_q) begin
						total_q <= total_q - lss_pkg::TOTAL_BITS'(rd_data)
							+ lss_pkg::TOTAL_BITS'(weight_q);
					end
					done_q   <= 1'b1;
					winner_q <= '0;
					found_q  <= 1'b0;
					state_q  <= ST_IDLE;
				end
				ST_MUL: begin
					if (total_q == '0) begin
						done_q   <= 1'b1;
						winner_q <= '0;
						found_q  <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_st.hit || scan_st.last) begin
						done_q   <= 1'b1;
						winner_q <= scan_st.hit ? scan_st.idx : '0;
						found_q  <= scan_st.hit;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign winner        = 4'(winner_q);
	assign found         = found_q && done_q;
	assign total_tickets = 12'(total_q);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two result strobes in a row");

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> (total_q != '0))
		else $error("draw found a slot with an empty table");

	a_scan_ends_found: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_en && scan_st.last) |-> scan_st.hit)
		else $error("walk reached the last slot without passing the ticket");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while a request is still in progress");
`endif

endmodule

[tb/lottery_slot_selector_top_test.sv]
// Self-checking testbench for lottery_slot_selector_top: set and draw requests,
// results checked against a predictor of the weight table and the weighted draw.
// Depends on lss_pkg and the lottery_slot_selector_top RTL.
`timescale 1ns / 100ps

module lottery_slot_selector_top_test;
	import lss_pkg::*;

	localparam int ITEM_TARGET = 650;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE      = SLOTS + 8;
	localparam int MAX_GAP     = 18;

	typedef struct {
		logic        cmd;
		slot_addr_t  slot;
		weight_t     weight;
		logic [15:0] fraction;
		int unsigned gap;
		bit          drain;
	} request_t;

	typedef struct {
		slot_addr_t winner;
		logic       found;
		total_t     total;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        cmd = CMD_SET;
	logic [3:0]  slot = '0;
	logic [7:0]  weight = '0;
	logic [15:0] random_value = '0;
	logic        busy;
	logic        done;
	logic [3:0]  winner;
	logic        found;
	logic [11:0] total_tickets;

	request_t    pending_q[$];
	outcome_t    outcome_q[$];
	request_t    cur_req;
	bit          have_req = 1'b0;
	int unsigned gap_left = 0;
	int unsigned requests_taken = 0;
	int unsigned request_total = 0;
	int unsigned idle_cycles = 0;
	int unsigned errors = 0;
	bit          burst_mode = 1'b0;

	// Predictor state: one weight per slot and their sum.
	weight_t     slot_weights[SLOTS];
	total_t      ticket_sum = '0;

	lottery_slot_selector_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.slot          (slot),
		.weight        (weight),
		.random_value  (random_value),
		.done          (done),
		.winner        (winner),
		.found         (found),
		.total_tickets (total_tickets)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic outcome_t apply_request(request_t r);
		outcome_t    o;
		int unsigned ticket;
		int unsigned running;
		o.winner = '0;
		o.found  = 1'b0;
		if (r.cmd == CMD_SET) begin
			slot_weights[r.slot] = r.weight;
			ticket_sum = '0;
			for (int k = 0; k < SLOTS; k++)
				ticket_sum += total_t'(slot_weights[k]);
		end else if (ticket_sum != 0) begin
			ticket  = (32'(r.fraction) * 32'(ticket_sum)) >> RAND_BITS;
			running = 0;
			// The first slot whose running sum passes the ticket wins.
			for (int k = 0; k < SLOTS; k++) begin
				running += 32'(slot_weights[k]);
				if (!o.found && running > ticket) begin
					o.winner = slot_addr_t'(k);
					o.found  = 1'b1;
				end
			end
		end
		o.total = ticket_sum;
		return o;
	endfunction

	function automatic weight_t pick_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return weight_t'(1);
			default: return weight_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_fraction();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic queue_request(logic c, int unsigned s, weight_t w, logic [15:0] f, bit d);
		request_t r;
		r.cmd      = c;
		r.slot     = slot_addr_t'(s);
		r.weight   = w;
		r.fraction = f;
		r.gap      = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
		r.drain    = d;
		pending_q.push_back(r);
	endtask

	// Driver: a request stays on the bus until busy lets it through.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				outcome_q.push_back(apply_request(cur_req));
				requests_taken++;
				have_req = 1'b0;
			end
			if (!have_req && pending_q.size() != 0) begin
				cur_req  = pending_q.pop_front();
				gap_left = cur_req.gap;
				have_req = 1'b1;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (have_req && gap_left == 0
					&& !(cur_req.drain && outcome_q.size() != 0)) begin
				start        <= 1'b1;
				cmd          <= cur_req.cmd;
				slot         <= cur_req.slot;
				weight       <= cur_req.weight;
				random_value <= cur_req.fraction;
			end else begin
				start <= 1'b0;
				if (have_req && gap_left != 0)
					gap_left--;
			end
		end
	end

	// Monitor: each strobed result is matched with the oldest prediction.
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result winner %0d found %0d total %0d",
					$time, winner, found, total_tickets);
				errors++;
			end else begin
				exp_o = outcome_q.pop_front();
				if (winner !== exp_o.winner) begin
					$display("%0t: winner expected %0d actual %0d",
						$time, exp_o.winner, winner);
					errors++;
				end
				if (found !== exp_o.found) begin
					$display("%0t: found expected %0d actual %0d",
						$time, exp_o.found, found);
					errors++;
				end
				if (total_tickets !== exp_o.total) begin
					$display("%0t: total_tickets expected %0d actual %0d",
						$time, exp_o.total, total_tickets);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		for (int k = 0; k < SLOTS; k++)
			slot_weights[k] = '0;

		// Directed: empty draws, extreme weights and fractions, removal of slots.
		queue_request(CMD_DRAW, 3, '0, 16'hFFFF, 1'b0);
		queue_request(CMD_SET, 0, 8'd255, 16'h0000, 1'b0);
		queue_request(CMD_SET, 15, 8'd1, 16'hFFFF, 1'b0);
		queue_request(CMD_DRAW, 0, '0, 16'h0000, 1'b0);
		queue_request(CMD_DRAW, 15, '1, 16'hFFFF, 1'b0);
		queue_request(CMD_DRAW, 9, '0, 16'h8000, 1'b0);
		queue_request(CMD_SET, 0, 8'd0, 16'h0000, 1'b0);
		queue_request(CMD_DRAW, 0, '0, 16'h0000, 1'b0);
		queue_request(CMD_DRAW, 0, '0, 16'hFFFF, 1'b0);
		queue_request(CMD_SET, 15, 8'd0, 16'h0000, 1'b1);
		queue_request(CMD_DRAW, 5, '0, 16'h1234, 1'b1);
		queue_request(CMD_SET, 7, 8'd170, 16'hAAAA, 1'b0);
		queue_request(CMD_SET, 8, 8'd85, 16'h5555, 1'b0);
		queue_request(CMD_DRAW, 10, '0, 16'h5555, 1'b0);
		queue_request(CMD_DRAW, 10, '0, 16'hAAAA, 1'b0);
		queue_request(CMD_DRAW, 10, '0, 16'hFFFF, 1'b0);

		// Random: mixed traffic, full tables at the largest total, and cleared tables.
		while (pending_q.size() < ITEM_TARGET) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 4))
				0: begin
					for (int s = 0; s < SLOTS; s++)
						queue_request(CMD_SET, s, '1, pick_fraction(), 1'b0);
					repeat (6)
						queue_request(CMD_DRAW, $urandom_range(0, 15), pick_weight(),
							pick_fraction(), 1'b0);
				end
				1: begin
					for (int s = 0; s < SLOTS; s++)
						queue_request(CMD_SET, s, '0, pick_fraction(), 1'b0);
					repeat (2)
						queue_request(CMD_DRAW, $urandom_range(0, 15), pick_weight(),
							pick_fraction(), 1'b0);
				end
				default: begin
					repeat (20)
						queue_request(($urandom_range(0, 2) == 0) ? CMD_SET : CMD_DRAW,
							$urandom_range(0, 15), pick_weight(), pick_fraction(),
							$urandom_range(0, 39) == 0);
				end
			endcase
		end
		request_total = pending_q.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (!(requests_taken == request_total && outcome_q.size() == 0)
				&& idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d requests taken, %0d results due",
				$time, IDLE_LIMIT, requests_taken, outcome_q.size());
			errors++;
		end else begin
			repeat (SETTLE) @(posedge clk);
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
